@@ design/ebcc_pkg.sv @@
// Shared types and constants for the edge box crop and clip block.
package ebcc_pkg;

    // Fraction bits of the clip ratio t (unsigned Q1.30)
    localparam int T_FRAC = 30;

    // Width of the configuration register index
    localparam int CFG_IDX_W = 3;

    typedef enum logic [1:0] {
        MODE_ERROR = 2'd0,
        MODE_MOVE  = 2'd1,
        MODE_DROP  = 2'd2,
        MODE_KEEP  = 2'd3
    } mode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MIN_X = 3'd0,
        REG_MIN_Y = 3'd1,
        REG_MIN_Z = 3'd2,
        REG_MAX_X = 3'd3,
        REG_MAX_Y = 3'd4,
        REG_MAX_Z = 3'd5,
        REG_MODE  = 3'd6,
        REG_NONE  = 3'd7
    } reg_idx_t;

    // Per-edge decision flags carried down the cell chain
    typedef struct packed {
        logic keep;
        logic err;
        logic moved;
        logic mend;
    } flags_t;

endpackage

@@ design/edge_box_crop_and_clip_top.sv @@
// Top level of the edge box crop and clip block: config, cell chain, output skid.
//
//  channel | direction | handshake                  | payload
//  --------+-----------+----------------------------+---------------------------------
//  s_*     | in        | s_tvalid / s_tready        | s_tdata: first xyz, second xyz
//  m_*     | out       | m_tvalid / m_tready        | m_tdata: flags, clipped xyz
//  cfg_*   | in        | cfg_valid / cfg_ready      | cfg_index, cfg_data
//
//  One edge per cycle while s_tready is high; an edge passes through the
//  front cell, one divider cell per ratio bit, a min stage, one multiplier cell
//  per bit of t, and the output register.
//  Reset clears all valid flags and loads the full-range box with mode 1 (move).
//  A stall on m_* fills the one-entry skid; s_tready drops only while it is full.
//  cfg_ready is always high; write registers only while the block is idle.
module edge_box_crop_and_clip_top #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    // first_x, first_y, first_z, second_x, second_y, second_z (low bits first)
    input  logic [((6*COORD_WIDTH+7)/8)*8-1:0] s_tdata,
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // keep_edge, crossing_error, moved, moved_endpoint, clipped_x, clipped_y,
    // clipped_z (low bits first)
    output logic [((3*COORD_WIDTH+4+7)/8)*8-1:0] m_tdata,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [ebcc_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [COORD_WIDTH-1:0]           cfg_data
);
    import ebcc_pkg::*;

    localparam int W    = COORD_WIDTH;
    localparam int AW   = W + T_FRAC + 1;
    localparam int OW   = ((3*W+4+7)/8)*8;
    localparam int NDIV = T_FRAC;
    localparam int NMUL = T_FRAC + 1;

    // Configuration registers
    logic [2:0][W-1:0] box_min_reg, box_max_reg;
    mode_t             mode_reg;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int a = 0; a < 3; a++)
            begin
                box_min_reg[a] <= {1'b1, {(W-1){1'b0}}};
                box_max_reg[a] <= {1'b0, {(W-1){1'b1}}};
            end
            mode_reg <= MODE_MOVE;
        end
        else if (cfg_valid)
        begin
            case (reg_idx_t'(cfg_index))
                REG_MIN_X: box_min_reg[0] <= cfg_data;
                REG_MIN_Y: box_min_reg[1] <= cfg_data;
                REG_MIN_Z: box_min_reg[2] <= cfg_data;
                REG_MAX_X: box_max_reg[0] <= cfg_data;
                REG_MAX_Y: box_max_reg[1] <= cfg_data;
                REG_MAX_Z: box_max_reg[2] <= cfg_data;
                REG_MODE:  mode_reg <= mode_t'(cfg_data[1:0]);
                default:   ;
            endcase
        end
    end

    // Whole chain advances together whenever the skid entry is free
    logic skid_valid_reg, skid_valid_next;
    logic out_valid_reg, out_valid_next;
    logic en;

    assign en       = ~skid_valid_reg;
    assign s_tready = en;

    logic [2:0][W-1:0] p0, p1;
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            p0[a] = s_tdata[a*W +: W];
            p1[a] = s_tdata[(a+3)*W +: W];
        end
    end

    // Divider chain
    logic                   dv   [NDIV+1];
    flags_t                 dflg [NDIV+1];
    logic [2:0][W-1:0]      dpin [NDIV+1];
    logic [2:0][W-1:0]      dm   [NDIV+1];
    logic [2:0]             dneg [NDIV+1];
    logic [2:0]             dact [NDIV+1];
    logic [2:0][W-1:0]      drem [NDIV+1];
    logic [2:0][T_FRAC-1:0] dq   [NDIV+1];

    assign dq[0] = '0;

    ebcc_front #(.W(W)) u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .en      (en),
        .vin     (s_tvalid),
        .p0      (p0),
        .p1      (p1),
        .lo      (box_min_reg),
        .hi      (box_max_reg),
        .mode    (mode_reg),
        .v_reg   (dv[0]),
        .flg_reg (dflg[0]),
        .pin_reg (dpin[0]),
        .m_reg   (dm[0]),
        .neg_reg (dneg[0]),
        .act_reg (dact[0]),
        .rem_reg (drem[0])
    );

    for (genvar i = 0; i < NDIV; i++)
    begin : g_div
        ebcc_div_cell #(.W(W)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vin     (dv[i]),
            .flg_in  (dflg[i]),
            .pin_in  (dpin[i]),
            .m_in    (dm[i]),
            .neg_in  (dneg[i]),
            .act_in  (dact[i]),
            .rem_in  (drem[i]),
            .q_in    (dq[i]),
            .v_reg   (dv[i+1]),
            .flg_reg (dflg[i+1]),
            .pin_reg (dpin[i+1]),
            .m_reg   (dm[i+1]),
            .neg_reg (dneg[i+1]),
            .act_reg (dact[i+1]),
            .rem_reg (drem[i+1]),
            .q_reg   (dq[i+1])
        );
    end

    // t_max: smallest active ratio, starting from 1.0
    logic [T_FRAC:0] tmax;
    always_comb
    begin
        tmax = {1'b1, {T_FRAC{1'b0}}};
        for (int a = 0; a < 3; a++)
            if (dact[NDIV][a] && {1'b0, dq[NDIV][a]} < tmax)
                tmax = {1'b0, dq[NDIV][a]};
    end

    // Multiplier chain
    logic                   mv   [NMUL+1];
    flags_t                 mflg [NMUL+1];
    logic [2:0][W-1:0]      mpin [NMUL+1];
    logic [2:0][W-1:0]      mm   [NMUL+1];
    logic [2:0]             mneg [NMUL+1];
    logic [T_FRAC:0]        mt   [NMUL+1];
    logic [2:0][AW-1:0]     macc [NMUL+1];

    logic                   tv_reg;
    flags_t                 tflg_reg;
    logic [2:0][W-1:0]      tpin_reg, tm_reg;
    logic [2:0]             tneg_reg;
    logic [T_FRAC:0]        tt_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tv_reg <= 1'b0;
        else if (en)
            tv_reg <= dv[NDIV];
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            tflg_reg <= dflg[NDIV];
            tpin_reg <= dpin[NDIV];
            tm_reg   <= dm[NDIV];
            tneg_reg <= dneg[NDIV];
            tt_reg   <= tmax;
        end
    end

    assign mv[0]   = tv_reg;
    assign mflg[0] = tflg_reg;
    assign mpin[0] = tpin_reg;
    assign mm[0]   = tm_reg;
    assign mneg[0] = tneg_reg;
    assign mt[0]   = tt_reg;
    assign macc[0] = '0;

    for (genvar i = 0; i < NMUL; i++)
    begin : g_mul
        ebcc_mul_cell #(.W(W)) u_cell (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .vin     (mv[i]),
            .flg_in  (mflg[i]),
            .pin_in  (mpin[i]),
            .m_in    (mm[i]),
            .neg_in  (mneg[i]),
            .t_in    (mt[i]),
            .acc_in  (macc[i]),
            .v_reg   (mv[i+1]),
            .flg_reg (mflg[i+1]),
            .pin_reg (mpin[i+1]),
            .m_reg   (mm[i+1]),
            .neg_reg (mneg[i+1]),
            .t_reg   (mt[i+1]),
            .acc_reg (macc[i+1])
        );
    end

    // Final point: step from the inside endpoint by floor(t * span), toward outside
    logic [W-1:0]  off [3];
    logic [W-1:0]  pt  [3];
    logic [OW-1:0] res;
    flags_t        fl;

    always_comb
    begin
        fl  = mflg[NMUL];
        res = '0;
        res[0] = fl.keep;
        res[1] = fl.err;
        res[2] = fl.moved;
        res[3] = fl.mend;
        for (int a = 0; a < 3; a++)
        begin
            off[a] = macc[NMUL][a][W+T_FRAC-1:T_FRAC];
            pt[a]  = mneg[NMUL][a] ? mpin[NMUL][a] - off[a] : mpin[NMUL][a] + off[a];
            res[4 + a*W +: W] = fl.moved ? pt[a] : '0;
        end
    end

    // Output register with one skid entry
    logic [OW-1:0] out_data_reg, skid_data_reg;
    logic          load_out, load_skid, take;

    assign take = out_valid_reg && m_tready;

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        skid_valid_next = skid_valid_reg;
        load_out  = 1'b0;
        load_skid = 1'b0;
        if (skid_valid_reg)
        begin
            if (take)
            begin
                load_out        = 1'b1;
                skid_valid_next = 1'b0;
            end
        end
        else if (mv[NMUL])
        begin
            if (!out_valid_reg || m_tready)
            begin
                load_out       = 1'b1;
                out_valid_next = 1'b1;
            end
            else
            begin
                load_skid       = 1'b1;
                skid_valid_next = 1'b1;
            end
        end
        else if (take)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_out)
            out_data_reg <= skid_valid_reg ? skid_data_reg : res;
        if (load_skid)
            skid_data_reg <= res;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // Skid entry is only ever filled behind a waiting result
    a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
        skid_valid_reg |-> out_valid_reg)
        else $error("skid holds data with no output pending");

    // A moved endpoint always belongs to a kept edge
    a_moved_kept: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[2] |-> m_tdata[0] && !m_tdata[1])
        else $error("moved edge not kept or flagged as error");

    // Crossing error drops the edge
    a_err_drop: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tdata[1] |-> !m_tdata[0])
        else $error("crossing error on a kept edge");

    // A result arriving at a stalled output fills the skid, which must block input
    a_block_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !m_tready && mv[NMUL] && !skid_valid_reg |=> !s_tready)
        else $error("input accepted with skid full");

endmodule

@@ design/ebcc_front.sv @@
// Front cell: endpoint inside tests, crossing decision and division setup.
module ebcc_front #(
    parameter int W = 32
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 en,
    input  logic                 vin,
    input  logic [2:0][W-1:0]    p0,
    input  logic [2:0][W-1:0]    p1,
    input  logic [2:0][W-1:0]    lo,
    input  logic [2:0][W-1:0]    hi,
    input  ebcc_pkg::mode_t      mode,
    output logic                 v_reg,
    output ebcc_pkg::flags_t     flg_reg,
    output logic [2:0][W-1:0]    pin_reg,
    output logic [2:0][W-1:0]    m_reg,
    output logic [2:0]           neg_reg,
    output logic [2:0]           act_reg,
    output logic [2:0][W-1:0]    rem_reg
);
    import ebcc_pkg::*;

    logic             in0, in1;
    flags_t           flg_next;
    logic [2:0][W-1:0] pin, pout, m_next, rem_next;
    logic [2:0]       neg_next, act_next;
    logic [W:0]       diff [3];
    logic [W:0]       ndiff [3];
    logic [W:0]       num_hi [3];
    logic [W:0]       num_lo [3];
    logic             above [3];
    logic             below [3];

    always_comb
    begin
        in0 = 1'b1;
        in1 = 1'b1;
        for (int a = 0; a < 3; a++)
        begin
            if ($signed(p0[a]) < $signed(lo[a]) || $signed(p0[a]) > $signed(hi[a]))
                in0 = 1'b0;
            if ($signed(p1[a]) < $signed(lo[a]) || $signed(p1[a]) > $signed(hi[a]))
                in1 = 1'b0;
        end
        flg_next = '0;
        if (in0 && in1)
            flg_next.keep = 1'b1;
        else if (in0 || in1)
        begin
            case (mode)
                MODE_ERROR: flg_next.err = 1'b1;
                MODE_DROP:  flg_next = '0;
                MODE_MOVE:
                begin
                    flg_next.keep  = 1'b1;
                    flg_next.moved = 1'b1;
                    flg_next.mend  = in0;
                end
                default:    flg_next.keep = 1'b1;
            endcase
        end
    end

    // From the inside point, each axis may cross either the upper or the lower bound
    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            pin[a]  = in0 ? p0[a] : p1[a];
            pout[a] = in0 ? p1[a] : p0[a];
            above[a] = $signed(pout[a]) > $signed(hi[a]);
            below[a] = $signed(pout[a]) < $signed(lo[a]);
            diff[a]   = {pout[a][W-1], pout[a]} - {pin[a][W-1], pin[a]};
            ndiff[a]  = {pin[a][W-1], pin[a]} - {pout[a][W-1], pout[a]};
            num_hi[a] = {hi[a][W-1], hi[a]} - {pin[a][W-1], pin[a]};
            num_lo[a] = {pin[a][W-1], pin[a]} - {lo[a][W-1], lo[a]};
            neg_next[a] = diff[a][W];
            m_next[a]   = diff[a][W] ? ndiff[a][W-1:0] : diff[a][W-1:0];
            act_next[a] = above[a] || below[a];
            rem_next[a] = above[a] ? num_hi[a][W-1:0] :
                          (below[a] ? num_lo[a][W-1:0] : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flg_reg <= flg_next;
            pin_reg <= pin;
            m_reg   <= m_next;
            neg_reg <= neg_next;
            act_reg <= act_next;
            rem_reg <= rem_next;
        end
    end

endmodule

@@ design/ebcc_div_cell.sv @@
// Divider cell: one restoring quotient bit per axis, handed to the next cell.
module ebcc_div_cell #(
    parameter int W = 32
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               en,
    input  logic                               vin,
    input  ebcc_pkg::flags_t                   flg_in,
    input  logic [2:0][W-1:0]                  pin_in,
    input  logic [2:0][W-1:0]                  m_in,
    input  logic [2:0]                         neg_in,
    input  logic [2:0]                         act_in,
    input  logic [2:0][W-1:0]                  rem_in,
    input  logic [2:0][ebcc_pkg::T_FRAC-1:0]   q_in,
    output logic                               v_reg,
    output ebcc_pkg::flags_t                   flg_reg,
    output logic [2:0][W-1:0]                  pin_reg,
    output logic [2:0][W-1:0]                  m_reg,
    output logic [2:0]                         neg_reg,
    output logic [2:0]                         act_reg,
    output logic [2:0][W-1:0]                  rem_reg,
    output logic [2:0][ebcc_pkg::T_FRAC-1:0]   q_reg
);
    import ebcc_pkg::*;

    logic [W:0]               sh [3];
    logic [W:0]               rn [3];
    logic [2:0]               ge;
    logic [2:0][W-1:0]        rem_next;
    logic [2:0][T_FRAC-1:0]   q_next;

    always_comb
    begin
        for (int a = 0; a < 3; a++)
        begin
            sh[a] = {rem_in[a], 1'b0};
            ge[a] = sh[a] >= {1'b0, m_in[a]};
            rn[a] = ge[a] ? sh[a] - {1'b0, m_in[a]} : sh[a];
            rem_next[a] = rn[a][W-1:0];
            q_next[a]   = {q_in[a][T_FRAC-2:0], ge[a]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flg_reg <= flg_in;
            pin_reg <= pin_in;
            m_reg   <= m_in;
            neg_reg <= neg_in;
            act_reg <= act_in;
            rem_reg <= rem_next;
            q_reg   <= q_next;
        end
    end

endmodule

@@ design/ebcc_mul_cell.sv @@
// Multiplier cell: one shift-and-add step of t times the axis span.
module ebcc_mul_cell #(
    parameter int W = 32
) (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   en,
    input  logic                                   vin,
    input  ebcc_pkg::flags_t                       flg_in,
    input  logic [2:0][W-1:0]                      pin_in,
    input  logic [2:0][W-1:0]                      m_in,
    input  logic [2:0]                             neg_in,
    input  logic [ebcc_pkg::T_FRAC:0]              t_in,
    input  logic [2:0][W+ebcc_pkg::T_FRAC:0]       acc_in,
    output logic                                   v_reg,
    output ebcc_pkg::flags_t                       flg_reg,
    output logic [2:0][W-1:0]                      pin_reg,
    output logic [2:0][W-1:0]                      m_reg,
    output logic [2:0]                             neg_reg,
    output logic [ebcc_pkg::T_FRAC:0]              t_reg,
    output logic [2:0][W+ebcc_pkg::T_FRAC:0]       acc_reg
);
    import ebcc_pkg::*;

    localparam int AW = W + T_FRAC + 1;

    logic [2:0][AW-1:0] acc_next;

    // Most significant bit of t first
    always_comb
    begin
        for (int a = 0; a < 3; a++)
            acc_next[a] = {acc_in[a][AW-2:0], 1'b0} +
                          (t_in[T_FRAC] ? {{(T_FRAC+1){1'b0}}, m_in[a]} : '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            v_reg <= 1'b0;
        else if (en)
            v_reg <= vin;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flg_reg <= flg_in;
            pin_reg <= pin_in;
            m_reg   <= m_in;
            neg_reg <= neg_in;
            t_reg   <= {t_in[T_FRAC-1:0], 1'b0};
            acc_reg <= acc_next;
        end
    end

endmodule
